### src/pdrt_pkg.sv
// ----------------------------------------------------------------------------
// pdrt_pkg
// Types, codes and helpers shared by the packed record table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pdrt_pkg;

  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_FINISH   = 2'd1,
    OP_RD_CLASS = 2'd2,
    OP_RD_OFFS  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BEYOND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_FWD_ID_W   = 3'd0,
    CFG_FWD_OFS_W  = 3'd1,
    CFG_REV_ID_W   = 3'd2,
    CFG_REV_OFS_W  = 3'd3,
    CFG_SHARED_N   = 3'd4,
    CFG_TAIL_FWD   = 3'd5,
    CFG_ID_LIMIT   = 3'd6,
    CFG_SUBJ_CNT   = 3'd7
  } cfg_idx_e;

  // how the pending result is built
  typedef enum logic [3:0] {
    RES_NONE,
    RES_FULL,
    RES_OK,
    RES_ERR,
    RES_CLASS,
    RES_FLAG,
    RES_FIRST_ZERO,
    RES_WALK,
    RES_WALK_ZERO
  } res_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] id;
    logic        permutation;
    logic [31:0] forward_class_id;
    logic [31:0] forward_offset;
    logic [31:0] reverse_class_id;
    logic [31:0] reverse_offset;
  } in_item_t;

  typedef struct packed {
    logic [31:0] class_id;
    logic [31:0] raw_offset;
    logic [31:0] block_start;
    logic [31:0] block_size;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       check;
    logic       push;
    logic [1:0] field;
    logic       rec_inc;
    logic       flush;
    logic       save_end;
    logic       dec;
    res_e       res;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic fit;
    logic err;
    logic flagged;
    logic id_one;
  } sts_t;

  function automatic logic [5:0] clampw(input logic [5:0] w);
    return (w > 6'd32) ? 6'd32 : w;
  endfunction

  function automatic logic [31:0] lowmask(input logic [5:0] w);
    return (w >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w[4:0]) - 32'd1);
  endfunction

endpackage

`default_nettype wire

### src/pdrt_ctrl.sv
// ----------------------------------------------------------------------------
// pdrt_ctrl
// Sequencer for append, finish, class and offset queries with backward walk.
// ----------------------------------------------------------------------------
`default_nettype none

module pdrt_ctrl import pdrt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] in_op_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output cmd_t            cmd_o,
  input  wire sts_t       sts_i
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_PUSH  = 9'b000000100,
    S_FLUSH = 9'b000001000,
    S_ADDR  = 9'b000010000,
    S_MULT  = 9'b000100000,
    S_READ  = 9'b001000000,
    S_EXTR  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  op_e        op_q, op_d;
  logic       first_q, first_d;
  logic [1:0] fld_q, fld_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    first_d     = first_q;
    fld_d       = fld_q;
    cmd_o       = '0;
    cmd_o.res   = RES_NONE;
    cmd_o.field = fld_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          op_d       = op_e'(in_op_i);
          first_d    = 1'b1;
          case (op_e'(in_op_i))
            OP_APPEND: state_d = S_CHECK;
            OP_FINISH: state_d = S_FLUSH;
            default:   state_d = S_ADDR;
          endcase
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        fld_d       = 2'd0;
        if (sts_i.fit) begin
          state_d = S_PUSH;
        end else begin
          cmd_o.res = RES_FULL;
          state_d   = S_DONE;
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        fld_d      = fld_q + 2'd1;
        if (fld_q == 2'd3) begin
          cmd_o.rec_inc = 1'b1;
          cmd_o.res     = RES_OK;
          state_d       = S_DONE;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        cmd_o.res   = RES_OK;
        state_d     = S_DONE;
      end
      S_ADDR: state_d = S_MULT;
      S_MULT: state_d = S_READ;
      S_READ: state_d = S_EXTR;
      S_EXTR: begin
        state_d = S_DONE;
        if (sts_i.err) begin
          cmd_o.res = RES_ERR;
        end else if (op_q == OP_RD_CLASS) begin
          cmd_o.res = RES_CLASS;
        end else if (first_q) begin
          if (sts_i.flagged) begin
            cmd_o.res = RES_FLAG;
          end else if (sts_i.id_one) begin
            cmd_o.res = RES_FIRST_ZERO;
          end else begin
            // walk back over flagged predecessors
            cmd_o.save_end = 1'b1;
            cmd_o.dec      = 1'b1;
            first_d        = 1'b0;
            state_d        = S_ADDR;
          end
        end else if (!sts_i.flagged) begin
          cmd_o.res = RES_WALK;
        end else if (sts_i.id_one) begin
          cmd_o.res = RES_WALK_ZERO;
        end else begin
          cmd_o.dec = 1'b1;
          state_d   = S_ADDR;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_APPEND;
      first_q     <= 1'b0;
      fld_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      first_q     <= first_d;
      fld_q       <= fld_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_done_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not delivered to output register");

  a_push_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH && fld_q == 2'd3) |=> (state_q == S_DONE))
    else $error("append did not end after the fourth field");

  a_read_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADDR) |=> (state_q == S_MULT) ##1 (state_q == S_READ)
                            ##1 (state_q == S_EXTR))
    else $error("read sequence broken");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted item left controller idle");

endmodule

`default_nettype wire

### src/pdrt_dp.sv
// ----------------------------------------------------------------------------
// pdrt_dp
// Datapath: config registers, bit packer, word store and field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

module pdrt_dp import pdrt_pkg::*; #(
  parameter int STORE_WORDS = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire in_item_t    in_item_i,
  output out_item_t        out_item_o,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int WW = AW + 1;
  localparam logic [WW+5:0] CAP = (WW + 6)'(STORE_WORDS) << 5;

  // configuration
  logic [5:0]  fiw_q, fow_q, riw_q, row_q;
  logic [31:0] shared_n_q, id_limit_q, subj_cnt_q;
  logic        tail_fwd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiw_q <= '0; fow_q <= '0; riw_q <= '0; row_q <= '0;
      shared_n_q <= '0; tail_fwd_q <= 1'b0; id_limit_q <= '0; subj_cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FWD_ID_W:  fiw_q      <= cfg_data_i[5:0];
        CFG_FWD_OFS_W: fow_q      <= cfg_data_i[5:0];
        CFG_REV_ID_W:  riw_q      <= cfg_data_i[5:0];
        CFG_REV_OFS_W: row_q      <= cfg_data_i[5:0];
        CFG_SHARED_N:  shared_n_q <= cfg_data_i;
        CFG_TAIL_FWD:  tail_fwd_q <= cfg_data_i[0];
        CFG_ID_LIMIT:  id_limit_q <= cfg_data_i;
        CFG_SUBJ_CNT:  subj_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [5:0] fi, fo, ri, ro, ti, to_w;
  logic [7:0] sw, tw;
  assign fi   = clampw(fiw_q);
  assign fo   = clampw(fow_q);
  assign ri   = clampw(riw_q);
  assign ro   = clampw(row_q);
  assign ti   = tail_fwd_q ? fi : ri;
  assign to_w = tail_fwd_q ? fo : ro;
  assign sw   = 8'(fi) + 8'(fo) + 8'(ri) + 8'(ro);
  assign tw   = 8'(ti) + 8'(to_w);

  // size of the shared region, follows config
  logic [39:0] base_q;
  always_ff @(posedge clk_i) base_q <= 40'(shared_n_q) * 40'(sw);

  // item and writer state
  in_item_t      item_q;
  logic [31:0]   cur_q, endv_q, rec_q, buf_q;
  logic [WW-1:0] wwi_q;
  logic [4:0]    fill_q;
  logic          shared_q;

  // packer
  logic [31:0] pv;
  logic [5:0]  pw;
  logic        pres;
  logic [63:0] win;
  logic [5:0]  nf;
  logic [6:0]  psh;
  logic        mem_we;
  logic [31:0] mem_wd;

  always_comb begin
    pres = shared_q || (cmd_i.field[1] ? !tail_fwd_q : tail_fwd_q);
    case (cmd_i.field)
      2'd0:    begin pv = item_q.forward_class_id; pw = fi; end
      2'd1:    begin pv = item_q.forward_offset;   pw = fo; end
      2'd2:    begin pv = item_q.reverse_class_id; pw = ri; end
      default: begin pv = item_q.reverse_offset;   pw = ro; end
    endcase
    if (!pres) pw = 6'd0;
    psh = 7'd64 - 7'(fill_q) - 7'(pw);
    win = {buf_q, 32'd0} | ({32'd0, pv & lowmask(pw)} << psh);
    nf  = 6'(fill_q) + pw;
    mem_we = 1'b0;
    mem_wd = win[63:32];
    if (cmd_i.push && nf >= 6'd32) mem_we = 1'b1;
    if (cmd_i.flush && fill_q != 5'd0) begin
      mem_we = 1'b1;
      mem_wd = buf_q;
    end
    if (wwi_q >= WW'(STORE_WORDS)) mem_we = 1'b0;
  end

  // append fit check
  logic [WW+5:0] need;
  logic          shr_now;
  logic [7:0]    rb;
  assign shr_now = rec_q < shared_n_q;
  assign rb      = shr_now ? sw : tw;
  assign need    = (WW + 6)'({wwi_q, fill_q}) + (WW + 6)'(rb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wwi_q    <= '0;
      fill_q   <= '0;
      buf_q    <= '0;
      rec_q    <= '0;
      shared_q <= 1'b0;
    end else begin
      if (cmd_i.check) shared_q <= shr_now;
      if (cmd_i.rec_inc) rec_q <= rec_q + 32'd1;
      if (cmd_i.push) begin
        if (nf >= 6'd32) begin
          wwi_q  <= wwi_q + WW'(1);
          buf_q  <= win[31:0];
          fill_q <= 5'(nf - 6'd32);
        end else begin
          buf_q  <= win[63:32];
          fill_q <= nf[4:0];
        end
      end else if (cmd_i.flush && fill_q != 5'd0) begin
        wwi_q  <= wwi_q + WW'(1);
        buf_q  <= '0;
        fill_q <= '0;
      end
    end
  end

  // stage 1: id mapping and field location
  logic        want_ofs;
  logic [31:0] m;
  logic        in_shr;
  logic [31:0] ma_q;
  logic [7:0]  mb_q;
  logic [6:0]  fadd_q;
  logic [5:0]  w_q, w2_q;
  logic        tail_q, mzero_q, mzero2_q;
  logic [5:0]  wsel;
  logic [6:0]  fsel;

  assign want_ofs = (op_e'(item_q.operation) == OP_RD_OFFS);

  always_comb begin
    m = (item_q.permutation && cur_q > id_limit_q) ? cur_q - subj_cnt_q : cur_q;
    in_shr = (m <= shared_n_q);
    if (in_shr) begin
      if (!item_q.permutation) begin
        fsel = want_ofs ? 7'(fi) : 7'd0;
        wsel = want_ofs ? fo : fi;
      end else begin
        fsel = 7'(fi) + 7'(fo) + (want_ofs ? 7'(ri) : 7'd0);
        wsel = want_ofs ? ro : ri;
      end
    end else begin
      fsel = want_ofs ? 7'(ti) : 7'd0;
      wsel = want_ofs ? to_w : ti;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q    <= in_shr ? m - 32'd1 : m - shared_n_q - 32'd1;
    mb_q    <= in_shr ? sw : tw;
    fadd_q  <= fsel;
    w_q     <= wsel;
    tail_q  <= !in_shr;
    mzero_q <= (m == 32'd0);
  end

  // stage 2: bit address
  logic [40:0] start_q;
  always_ff @(posedge clk_i) begin
    start_q  <= (tail_q ? 41'(base_q) : 41'd0) + 41'(ma_q * 40'(mb_q)) + 41'(fadd_q);
    w2_q     <= w_q;
    mzero2_q <= mzero_q;
  end

  // stage 3: range check and word reads
  logic [31:0] mem [STORE_WORDS];
  logic [31:0] hi_q, lo_q;
  logic [4:0]  off_q;
  logic [5:0]  w3_q;
  logic        err_q;
  logic [AW-1:0] ra;
  logic [41:0] endbit;
  logic [41:0] lim;

  assign ra     = start_q[AW+4:5];
  assign endbit = 42'(start_q) + 42'(w2_q);
  assign lim    = 42'({wwi_q, 5'd0});

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wwi_q[AW-1:0]] <= mem_wd;
    hi_q  <= mem[ra];
    lo_q  <= mem[ra + AW'(1)];
    off_q <= start_q[4:0];
    w3_q  <= w2_q;
    err_q <= mzero2_q || (w2_q != 6'd0 && endbit > lim);
  end

  // stage 4: extract
  logic [63:0] pair;
  logic [6:0]  esh;
  logic [31:0] val, fm;
  logic [5:0]  ow;

  assign esh  = 7'd64 - 7'(off_q) - 7'(w3_q);
  assign pair = {hi_q, lo_q} >> esh;
  assign val  = pair[31:0] & lowmask(w3_q);
  assign ow   = item_q.permutation ? ro : fo;
  assign fm   = (ow == 6'd0) ? 32'd0 : (32'd1 << 5'(ow - 6'd1));

  assign sts_o.fit     = (need <= CAP);
  assign sts_o.err     = err_q;
  assign sts_o.flagged = |(val & fm);
  assign sts_o.id_one  = (cur_q == 32'd1);

  // result assembly
  out_item_t res_q, out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
      cur_q  <= in_item_i.id;
    end else if (cmd_i.dec) begin
      cur_q <= cur_q - 32'd1;
    end
    if (cmd_i.save_end) endv_q <= val;
    case (cmd_i.res)
      RES_FULL:  res_q <= '{32'd0, 32'd0, 32'd0, 32'd0, ST_FULL};
      RES_OK:    res_q <= '{32'd0, 32'd0, 32'd0, 32'd0, ST_OK};
      RES_ERR:   res_q <= '{32'd0, 32'd0, 32'd0, 32'd0, ST_BEYOND};
      RES_CLASS: res_q <= '{val, 32'd0, 32'd0, 32'd0, ST_OK};
      RES_FLAG:  res_q <= '{32'd0, val, val & ~fm, 32'd0, ST_OK};
      RES_FIRST_ZERO: res_q <= '{32'd0, val, 32'd0, val, ST_OK};
      RES_WALK:  res_q <= '{32'd0, endv_q, val, endv_q - val, ST_OK};
      RES_WALK_ZERO: res_q <= '{32'd0, endv_q, 32'd0, endv_q, ST_OK};
      default: ;
    endcase
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

### src/packed_dual_record_table.sv
// append checks fit then packs fields; finish flushes the bit buffer; a query
// steps address, multiply, word-pair read, extract, again per walked predecessor
// one item is worked at a time; the output register lets the next item enter
// while a result waits; read rate is set by the address multiply and store port
// reset clears control, write pointer, bit buffer and record count; store
// words are undefined until written and get no clearing pass
// ----------------------------------------------------------------------------
// packed_dual_record_table
// Bit-packed table of forward and reverse class ids and offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_dual_record_table import pdrt_pkg::*; #(
  parameter int STORE_WORDS = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_item_o
);

  cmd_t cmd;
  sts_t sts;

  pdrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_op_i     (in_item_i.operation),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pdrt_dp #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire
